>>> rtl/yaw_pitch_camera_update_unit_macros.svh
// Assertion macros used by the checker file of the camera update unit.
`ifndef YAW_PITCH_CAMERA_UPDATE_UNIT_MACROS_SVH
`define YAW_PITCH_CAMERA_UPDATE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define YPC_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ypc: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define YPC_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ypc: next-cycle check failed");

`endif

>>> rtl/ypc_pkg.sv
// Shared constants, types and tables of the camera update unit.
package ypc_pkg;

   // Configuration register indexes.
   localparam logic [2:0] CSR_MOVE_SPEED  = 3'd0;
   localparam logic [2:0] CSR_LOOK_SENS   = 3'd1;
   localparam logic [2:0] CSR_WORLD_UP_X  = 3'd2;
   localparam logic [2:0] CSR_WORLD_UP_Y  = 3'd3;
   localparam logic [2:0] CSR_WORLD_UP_Z  = 3'd4;

   // Event kinds.
   localparam logic OP_MOVE = 1'b0;
   localparam logic OP_LOOK = 1'b1;

   // Move directions.
   localparam logic [2:0] DIR_LEFT     = 3'd0;
   localparam logic [2:0] DIR_RIGHT    = 3'd1;
   localparam logic [2:0] DIR_FORWARD  = 3'd2;
   localparam logic [2:0] DIR_BACKWARD = 3'd3;
   localparam logic [2:0] DIR_UP       = 3'd4;
   localparam logic [2:0] DIR_DOWN     = 3'd5;

   // Angles in Q16 degrees.
   localparam logic [24:0] YAW_RESET     = 25'd17694720;
   localparam logic [33:0] YAW_MOD       = 34'd23592960;
   localparam logic [33:0] YAW_MOD_TOP   = 34'd3019898880;
   localparam logic signed [35:0] PITCH_LIM = 36'sd5832704;
   localparam logic signed [26:0] DEG90  = 27'sd5898240;
   localparam logic signed [26:0] DEG180 = 27'sd11796480;
   localparam logic signed [26:0] DEG360 = 27'sd23592960;

   // CORDIC start value in Q2.30 and unit length in Q1.14.
   localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
   localparam logic signed [15:0] ONE_Q14   = 16'sd16384;

   // Request into the normalizer.
   typedef struct packed {
      logic             start;
      logic [62:0]      sum;
      logic [2:0][31:0] mag;
      logic [2:0]       neg;
   } norm_req_type;

   // Answer from the normalizer.
   typedef struct packed {
      logic             done;
      logic [2:0][15:0] vec;
   } norm_rsp_type;

   // Arctangent of 2^-i in Q16 degrees.
   function automatic logic signed [25:0] atan_deg(input logic [3:0] i);
      logic signed [25:0] v;
      case (i)
         4'd0:    v = 26'sd2949120;
         4'd1:    v = 26'sd1740967;
         4'd2:    v = 26'sd919879;
         4'd3:    v = 26'sd466945;
         4'd4:    v = 26'sd234379;
         4'd5:    v = 26'sd117304;
         4'd6:    v = 26'sd58666;
         4'd7:    v = 26'sd29335;
         4'd8:    v = 26'sd14668;
         4'd9:    v = 26'sd7334;
         4'd10:   v = 26'sd3667;
         4'd11:   v = 26'sd1833;
         4'd12:   v = 26'sd917;
         4'd13:   v = 26'sd458;
         4'd14:   v = 26'sd229;
         default: v = 26'sd115;
      endcase
      return v;
   endfunction

endpackage

>>> rtl/ypc_norm.sv
// Vector normalizer: bit-pair square root, then one restoring divide per component.
module ypc_norm (
   input  logic                  clock,
   input  logic                  reset,
   input  ypc_pkg::norm_req_type req,
   output ypc_pkg::norm_rsp_type rsp
);
   import ypc_pkg::*;

   typedef enum logic [2:0] {
      N_IDLE = 3'b001,
      N_SQRT = 3'b010,
      N_DIV  = 3'b100
   } nstate_type;

   nstate_type       state_ff, state_in;
   logic [62:0]      n_ff, n_in, r_ff, r_in, b_ff, b_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic [1:0]       comp_ff, comp_in;
   logic [46:0]      num_ff, num_in, dv_ff, dv_in;
   logic [14:0]      q_ff, q_in;
   logic [2:0][31:0] mag_ff, mag_in;
   logic [2:0]       neg_ff, neg_in;
   logic [2:0][15:0] vec_ff, vec_in;
   logic             done_ff, done_in;

   logic [63:0] trial;
   logic [31:0] len;
   logic [14:0] q_fin;
   logic [14:0] q_sat;

   assign len = r_ff[31:0];

   // Sequencer for the root and the three quotients.
   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      r_in     = r_ff;
      b_in     = b_ff;
      cnt_in   = cnt_ff;
      comp_in  = comp_ff;
      num_in   = num_ff;
      dv_in    = dv_ff;
      q_in     = q_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      vec_in   = vec_ff;
      done_in  = 1'b0;
      trial    = {1'b0, r_ff} + {1'b0, b_ff};
      q_fin    = {q_ff[13:0], (num_ff >= dv_ff)};
      q_sat    = (q_fin > 15'd16384) ? 15'd16384 : q_fin;
      unique case (state_ff)
         N_IDLE: begin
            if (req.start) begin
               n_in     = req.sum;
               r_in     = '0;
               b_in     = {1'b1, 62'b0};
               mag_in   = req.mag;
               neg_in   = req.neg;
               cnt_in   = '0;
               state_in = N_SQRT;
            end
         end
         N_SQRT: begin
            if ({1'b0, n_ff} >= trial) begin
               n_in = n_ff - trial[62:0];
               r_in = (r_ff >> 1) + b_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            b_in   = b_ff >> 2;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               cnt_in   = '0;
               comp_in  = '0;
               state_in = N_DIV;
            end
         end
         N_DIV: begin
            if (cnt_ff == 5'd0) begin
               // Load numerator with rounding term and the top divisor.
               num_in = {1'b0, mag_ff[comp_ff], 14'b0} + {16'b0, len[31:1]};
               dv_in  = {1'b0, len, 14'b0};
               q_in   = '0;
               cnt_in = 5'd1;
            end else begin
               if (num_ff >= dv_ff) begin
                  num_in = num_ff - dv_ff;
               end
               q_in   = q_fin;
               dv_in  = dv_ff >> 1;
               cnt_in = cnt_ff + 5'd1;
               if (cnt_ff == 5'd15) begin
                  if (len == '0) begin
                     vec_in[comp_ff] = '0;
                  end else if (neg_ff[comp_ff]) begin
                     vec_in[comp_ff] = -{1'b0, q_sat};
                  end else begin
                     vec_in[comp_ff] = {1'b0, q_sat};
                  end
                  cnt_in = '0;
                  if (comp_ff == 2'd2) begin
                     done_in  = 1'b1;
                     state_in = N_IDLE;
                  end else begin
                     comp_in = comp_ff + 2'd1;
                  end
               end
            end
         end
         default: state_in = N_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
         comp_ff  <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
         comp_ff  <= comp_in;
      end
      n_ff   <= n_in;
      r_ff   <= r_in;
      b_ff   <= b_in;
      num_ff <= num_in;
      dv_ff  <= dv_in;
      q_ff   <= q_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      vec_ff <= vec_in;
   end

   assign rsp.done = done_ff;
   assign rsp.vec  = vec_ff;

endmodule

>>> rtl/yaw_pitch_camera_update_unit.sv
// Top level of the fly camera: event sequencer, shared multiplier and CORDIC.
//
//  Channel | Direction | Handshake           | Payload
//  req     | in        | req_tvalid/tready   | tdata 56b, tuser = opcode
//  rsp     | out       | rsp_tvalid/tready   | tdata 240b position and vectors
//  csr     | in        | csr_we              | csr_addr 3b, csr_wdata 16b
//
// A look event does two 16-step CORDIC runs and three
// normalizations, each a 32-step square root and three 15-step divides.
// A move event runs on the shared multiplier.
// One event is in work at a time; a result waits in the output register.
// Reset is synchronous and restores the reset pose and register values.
module yaw_pitch_camera_update_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // move_dir[2:0], delta_time[18:3], look_dx[34:19], look_dy[50:35], zero pad
   input  logic [55:0]  req_tdata,
   // opcode[0]
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pos_x, pos_y, pos_z (32b each), front_x..z, right_x..z, up_x..z (16b each)
   output logic [239:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [15:0]  csr_wdata
);
   import ypc_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_ANG   = 11'b00000000010,
      S_MOD   = 11'b00000000100,
      S_CORD  = 11'b00000001000,
      S_FRONT = 11'b00000010000,
      S_SQ    = 11'b00000100000,
      S_NORM  = 11'b00001000000,
      S_CROSS = 11'b00010000000,
      S_VEL   = 11'b00100000000,
      S_MOVE  = 11'b01000000000,
      S_OUT   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] k_ff, k_in;
   logic       ph_ff, ph_in;
   logic [3:0] cnt_ff, cnt_in;
   logic       sel_ff, sel_in;
   logic [1:0] nsel_ff, nsel_in;

   logic [2:0]         dir_ff, dir_in;
   logic [15:0]        dt_ff, dt_in;
   logic signed [15:0] dx_ff, dx_in, dy_ff, dy_in;

   logic [15:0]        speed_ff, speed_in, sens_ff, sens_in;
   logic signed [15:0] wu_ff [3], wu_in [3];

   logic [24:0]        yaw_ff, yaw_in;
   logic signed [23:0] pitch_ff, pitch_in;
   logic signed [31:0] pos_ff [3], pos_in [3];
   logic signed [15:0] front_ff [3], front_in [3];
   logic signed [15:0] right_ff [3], right_in [3];
   logic signed [15:0] up_ff [3], up_in [3];

   logic [33:0]        acc_ff, acc_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic signed [25:0] z_ff, z_in;
   logic               neg_ff, neg_in;
   logic signed [32:0] cy_ff, cy_in, sy_ff, sy_in, cp_ff, cp_in, sp_ff, sp_in;
   logic signed [32:0] raw_ff [3], raw_in [3];
   logic signed [32:0] tmp_ff, tmp_in;
   logic [62:0]        sum_ff, sum_in;
   logic [31:0]        vel_ff, vel_in;
   logic signed [65:0] prod_ff, prod_in;
   logic               nstart_ff, nstart_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [239:0]       rsp_data_ff, rsp_data_in;

   logic signed [32:0] mul_a, mul_b;
   logic [1:0]         ia, ib;
   logic signed [15:0] va [3], vb [3], mv [3];
   logic               mv_neg;

   logic signed [35:0] yaw_sum, pit_sum;
   logic [33:0]        msub;
   logic signed [26:0] ang, ang_r;
   logic signed [33:0] xs, ys, nx, ny;
   logic signed [65:0] rnd;
   logic signed [34:0] step, np;

   norm_req_type nreq;
   norm_rsp_type nrsp;

   ypc_norm u_norm (
      .clock (clock),
      .reset (reset),
      .req   (nreq),
      .rsp   (nrsp)
   );

   // Normalizer request built from the vector under work.
   always_comb begin
      nreq.start = nstart_ff;
      nreq.sum   = sum_ff;
      for (int i = 0; i < 3; i++) begin
         nreq.neg[i] = raw_ff[i][32];
         nreq.mag[i] = raw_ff[i][32] ? 32'(-raw_ff[i]) : raw_ff[i][31:0];
      end
   end

   // Cross product operand vectors and component order.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         va[i] = (nsel_ff == 2'd1) ? front_ff[i] : right_ff[i];
         vb[i] = (nsel_ff == 2'd1) ? wu_ff[i] : front_ff[i];
      end
      case (k_ff)
         3'd0:    begin ia = 2'd1; ib = 2'd2; end
         3'd1:    begin ia = 2'd2; ib = 2'd1; end
         3'd2:    begin ia = 2'd2; ib = 2'd0; end
         3'd3:    begin ia = 2'd0; ib = 2'd2; end
         3'd4:    begin ia = 2'd0; ib = 2'd1; end
         default: begin ia = 2'd1; ib = 2'd0; end
      endcase
   end

   // Direction vector and sign of a move.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         case (dir_ff)
            DIR_LEFT, DIR_RIGHT:       mv[i] = right_ff[i];
            DIR_FORWARD, DIR_BACKWARD: mv[i] = front_ff[i];
            default:                   mv[i] = up_ff[i];
         endcase
      end
      mv_neg = (dir_ff == DIR_LEFT) || (dir_ff == DIR_BACKWARD) || (dir_ff == DIR_DOWN);
   end

   // Shared multiplier operand selection.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_ANG: begin
            mul_a = (k_ff == 3'd0) ? 33'(dx_ff) : 33'(dy_ff);
            mul_b = $signed({17'b0, sens_ff});
         end
         S_FRONT: begin
            mul_a = (k_ff == 3'd0) ? cy_ff : sy_ff;
            mul_b = cp_ff;
         end
         S_SQ: begin
            mul_a = raw_ff[k_ff[1:0]];
            mul_b = raw_ff[k_ff[1:0]];
         end
         S_CROSS: begin
            mul_a = 33'(va[ia]);
            mul_b = 33'(vb[ib]);
         end
         S_VEL: begin
            mul_a = $signed({17'b0, dt_ff});
            mul_b = $signed({17'b0, speed_ff});
         end
         S_MOVE: begin
            mul_a = $signed({1'b0, vel_ff});
            mul_b = 33'(mv[k_ff[1:0]]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // Datapath helpers for the angle update, CORDIC and rounding.
   always_comb begin
      yaw_sum = $signed({11'b0, yaw_ff}) + $signed(prod_ff[35:0])
              + $signed({2'b0, YAW_MOD_TOP});
      pit_sum = 36'(pitch_ff) + $signed(prod_ff[35:0]);
      msub    = YAW_MOD_TOP >> cnt_ff[2:0];
      ang     = sel_ff ? 27'(pitch_ff) : $signed({2'b0, yaw_ff});
      if (ang > DEG180) begin
         ang_r = ang - DEG360;
      end else if (ang <= -DEG180) begin
         ang_r = ang + DEG360;
      end else begin
         ang_r = ang;
      end
      xs = x_ff >>> cnt_ff;
      ys = y_ff >>> cnt_ff;
      if (z_ff >= 0) begin
         nx = x_ff - ys;
         ny = y_ff + xs;
      end else begin
         nx = x_ff + ys;
         ny = y_ff - xs;
      end
      rnd  = (state_ff == S_FRONT) ? (prod_ff + 66'sd536870912) >>> 30
                                   : (prod_ff + 66'sd2097152) >>> 22;
      step = 35'(rnd);
      np   = 35'(pos_ff[k_ff[1:0]]) + (mv_neg ? -step : step);
   end

   // Event sequencer.
   always_comb begin
      state_in  = state_ff;
      k_in      = k_ff;
      ph_in     = ~ph_ff;
      cnt_in    = cnt_ff;
      sel_in    = sel_ff;
      nsel_in   = nsel_ff;
      dir_in    = dir_ff;
      dt_in     = dt_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      speed_in  = speed_ff;
      sens_in   = sens_ff;
      yaw_in    = yaw_ff;
      pitch_in  = pitch_ff;
      acc_in    = acc_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      neg_in    = neg_ff;
      cy_in     = cy_ff;
      sy_in     = sy_ff;
      cp_in     = cp_ff;
      sp_in     = sp_ff;
      tmp_in    = tmp_ff;
      sum_in    = sum_ff;
      vel_in    = vel_ff;
      nstart_in = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      for (int i = 0; i < 3; i++) begin
         wu_in[i]    = wu_ff[i];
         pos_in[i]   = pos_ff[i];
         front_in[i] = front_ff[i];
         right_in[i] = right_ff[i];
         up_in[i]    = up_ff[i];
         raw_in[i]   = raw_ff[i];
      end

      // Register writes must arrive only while no event is in work; the block itself does not enforce this.
      if (csr_we) begin
         unique case (csr_addr)
            CSR_MOVE_SPEED: speed_in = csr_wdata;
            CSR_LOOK_SENS:  sens_in  = csr_wdata;
            CSR_WORLD_UP_X: wu_in[0] = csr_wdata;
            CSR_WORLD_UP_Y: wu_in[1] = csr_wdata;
            CSR_WORLD_UP_Z: wu_in[2] = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            ph_in = 1'b0;
            k_in  = '0;
            if (req_tvalid) begin
               dir_in = req_tdata[2:0];
               dt_in  = req_tdata[18:3];
               dx_in  = req_tdata[34:19];
               dy_in  = req_tdata[50:35];
               if (req_tuser[0] == OP_LOOK) begin
                  nsel_in  = '0;
                  state_in = S_ANG;
               end else if (req_tdata[2:0] <= DIR_DOWN) begin
                  state_in = S_VEL;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_ANG: begin
            if (ph_ff) begin
               if (k_ff == 3'd0) begin
                  acc_in = yaw_sum[33:0];
                  k_in   = 3'd1;
               end else begin
                  if (pit_sum > PITCH_LIM) begin
                     pitch_in = 24'(PITCH_LIM);
                  end else if (pit_sum < -PITCH_LIM) begin
                     pitch_in = 24'(-PITCH_LIM);
                  end else begin
                     pitch_in = pit_sum[23:0];
                  end
                  cnt_in   = '0;
                  state_in = S_MOD;
               end
            end
         end
         S_MOD: begin
            // Remove multiples of 360 degrees, largest first.
            if (acc_ff >= msub) begin
               acc_in = acc_ff - msub;
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd7) begin
               yaw_in   = (acc_ff >= msub) ? 25'(acc_ff - msub) : acc_ff[24:0];
               cnt_in   = '0;
               sel_in   = 1'b0;
               ph_in    = 1'b0;
               state_in = S_CORD;
            end
         end
         S_CORD: begin
            if (!ph_ff) begin
               // Fold the angle into the CORDIC range.
               x_in   = CORDIC_X0;
               y_in   = '0;
               cnt_in = '0;
               neg_in = 1'b0;
               if (ang_r > DEG90) begin
                  z_in   = 26'(ang_r - DEG180);
                  neg_in = 1'b1;
               end else if (ang_r < -DEG90) begin
                  z_in   = 26'(ang_r + DEG180);
                  neg_in = 1'b1;
               end else begin
                  z_in = 26'(ang_r);
               end
            end else begin
               ph_in  = 1'b1;
               x_in   = nx;
               y_in   = ny;
               z_in   = (z_ff >= 0) ? z_ff - atan_deg(cnt_ff) : z_ff + atan_deg(cnt_ff);
               cnt_in = cnt_ff + 4'd1;
               if (cnt_ff == 4'd15) begin
                  ph_in = 1'b0;
                  if (!sel_ff) begin
                     cy_in  = 33'(neg_ff ? -nx : nx);
                     sy_in  = 33'(neg_ff ? -ny : ny);
                     sel_in = 1'b1;
                  end else begin
                     cp_in    = 33'(neg_ff ? -nx : nx);
                     sp_in    = 33'(neg_ff ? -ny : ny);
                     k_in     = '0;
                     state_in = S_FRONT;
                  end
               end
            end
         end
         S_FRONT: begin
            if (ph_ff) begin
               if (k_ff == 3'd0) begin
                  raw_in[0] = 33'(rnd);
                  k_in      = 3'd1;
               end else begin
                  raw_in[2] = 33'(rnd);
                  raw_in[1] = sp_ff;
                  k_in      = '0;
                  sum_in    = '0;
                  state_in  = S_SQ;
               end
            end
         end
         S_SQ: begin
            if (ph_ff) begin
               sum_in = sum_ff + prod_ff[62:0];
               k_in   = k_ff + 3'd1;
               if (k_ff == 3'd2) begin
                  nstart_in = 1'b1;
                  state_in  = S_NORM;
               end
            end
         end
         S_NORM: begin
            ph_in = 1'b0;
            k_in  = '0;
            if (nrsp.done) begin
               for (int i = 0; i < 3; i++) begin
                  case (nsel_ff)
                     2'd0:    front_in[i] = nrsp.vec[i];
                     2'd1:    right_in[i] = nrsp.vec[i];
                     default: up_in[i]    = nrsp.vec[i];
                  endcase
               end
               if (nsel_ff == 2'd2) begin
                  state_in = S_OUT;
               end else begin
                  nsel_in  = nsel_ff + 2'd1;
                  state_in = S_CROSS;
               end
            end
         end
         S_CROSS: begin
            if (ph_ff) begin
               if (!k_ff[0]) begin
                  tmp_in = prod_ff[32:0];
               end else begin
                  raw_in[k_ff[2:1]] = tmp_ff - $signed(prod_ff[32:0]);
               end
               k_in = k_ff + 3'd1;
               if (k_ff == 3'd5) begin
                  k_in     = '0;
                  sum_in   = '0;
                  state_in = S_SQ;
               end
            end
         end
         S_VEL: begin
            if (ph_ff) begin
               vel_in   = prod_ff[31:0];
               k_in     = '0;
               state_in = S_MOVE;
            end
         end
         S_MOVE: begin
            if (ph_ff) begin
               // Saturating add of the rounded step.
               if (np > 35'sd2147483647) begin
                  pos_in[k_ff[1:0]] = 32'sh7fffffff;
               end else if (np < -35'sd2147483648) begin
                  pos_in[k_ff[1:0]] = 32'sh80000000;
               end else begin
                  pos_in[k_ff[1:0]] = np[31:0];
               end
               k_in = k_ff + 3'd1;
               if (k_ff == 3'd2) begin
                  state_in = S_OUT;
               end
            end
         end
         S_OUT: begin
            ph_in = 1'b0;
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {up_ff[2], up_ff[1], up_ff[0],
                               right_ff[2], right_ff[1], right_ff[0],
                               front_ff[2], front_ff[1], front_ff[0],
                               pos_ff[2], pos_ff[1], pos_ff[0]};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         k_ff         <= '0;
         ph_ff        <= 1'b0;
         cnt_ff       <= '0;
         sel_ff       <= 1'b0;
         nsel_ff      <= '0;
         nstart_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         speed_ff     <= 16'd640;
         sens_ff      <= 16'd6554;
         wu_ff[0]     <= '0;
         wu_ff[1]     <= ONE_Q14;
         wu_ff[2]     <= '0;
         yaw_ff       <= YAW_RESET;
         pitch_ff     <= '0;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0;
         end
         front_ff[0]  <= '0;
         front_ff[1]  <= '0;
         front_ff[2]  <= -ONE_Q14;
         right_ff[0]  <= ONE_Q14;
         right_ff[1]  <= '0;
         right_ff[2]  <= '0;
         up_ff[0]     <= '0;
         up_ff[1]     <= ONE_Q14;
         up_ff[2]     <= '0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         ph_ff        <= ph_in;
         cnt_ff       <= cnt_in;
         sel_ff       <= sel_in;
         nsel_ff      <= nsel_in;
         nstart_ff    <= nstart_in;
         rsp_valid_ff <= rsp_valid_in;
         speed_ff     <= speed_in;
         sens_ff      <= sens_in;
         yaw_ff       <= yaw_in;
         pitch_ff     <= pitch_in;
         for (int i = 0; i < 3; i++) begin
            wu_ff[i]    <= wu_in[i];
            pos_ff[i]   <= pos_in[i];
            front_ff[i] <= front_in[i];
            right_ff[i] <= right_in[i];
            up_ff[i]    <= up_in[i];
         end
      end
      dir_ff      <= dir_in;
      dt_ff       <= dt_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      acc_ff      <= acc_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      neg_ff      <= neg_in;
      cy_ff       <= cy_in;
      sy_ff       <= sy_in;
      cp_ff       <= cp_in;
      sp_ff       <= sp_in;
      tmp_ff      <= tmp_in;
      sum_ff      <= sum_in;
      vel_ff      <= vel_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
      for (int i = 0; i < 3; i++) begin
         raw_ff[i] <= raw_in[i];
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> rtl/ypc_checker.sv
// Port-level checker for the camera update unit, bound to the top level.
`include "yaw_pitch_camera_update_unit_macros.svh"

module ypc_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [239:0] rsp_tdata
);
   // A waiting result stays offered and unchanged.
   `YPC_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `YPC_ASSERT_NXT(a_rsp_stable, rsp_tvalid && !rsp_tready, rsp_tdata == $past(rsp_tdata))

   // One event at a time: a transfer in closes the input for the next cycle.
   `YPC_ASSERT_NXT(a_busy_after_req, req_tvalid && req_tready, !req_tready)

   // The offered front vector stays within unit length per component.
   `YPC_ASSERT_IMP(a_front_range, rsp_tvalid,
      ($signed(rsp_tdata[111:96]) >= -16384) && ($signed(rsp_tdata[111:96]) <= 16384) &&
      ($signed(rsp_tdata[127:112]) >= -16384) && ($signed(rsp_tdata[127:112]) <= 16384) &&
      ($signed(rsp_tdata[143:128]) >= -16384) && ($signed(rsp_tdata[143:128]) <= 16384))

endmodule

bind yaw_pitch_camera_update_unit ypc_checker u_ypc_checker (.*);
